// ----- rtl/dau_pkg.sv -----
package dau_pkg;

  localparam int DAY_BITS     = 14;
  localparam int FACT_W       = 16;
  localparam int TOT_W        = DAY_BITS + 17;
  localparam int RES_W        = TOT_W + FACT_W + 1;
  localparam int SEC_PER_DAY  = 86400;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_CMP   = 3'd3;
  localparam logic [2:0] OP_INC   = 3'd4;
  localparam logic [2:0] OP_DEC   = 3'd5;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [2:0] {
    K_NOP = 3'd0,
    K_ADD = 3'd1,
    K_SUB = 3'd2,
    K_MUL = 3'd3,
    K_CMP = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [TOT_W-1:0]         ta;
    logic [TOT_W-1:0]         tb;
    logic signed [FACT_W-1:0] factor;
  } item_t;

  typedef struct packed {
    logic zero;
    logic sat;
    logic lt;
    logic eq;
    logic gt;
  } flags_t;

endpackage

// ----- rtl/dau_front.sv -----
module dau_front import dau_pkg::*; (
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2:0]              operation_i,
  input  logic [DAY_BITS-1:0]     a_days_i,
  input  logic [4:0]              a_hours_i,
  input  logic [5:0]              a_minutes_i,
  input  logic [5:0]              a_seconds_i,
  input  logic [DAY_BITS-1:0]     b_days_i,
  input  logic [4:0]              b_hours_i,
  input  logic [5:0]              b_minutes_i,
  input  logic [5:0]              b_seconds_i,
  input  logic signed [FACT_W-1:0] factor_i,
  output logic                    q_valid_o,
  input  logic                    q_ready_i,
  output item_t                   item_o
);

  function automatic logic [TOT_W-1:0] to_total(
    input logic [DAY_BITS-1:0] d,
    input logic [4:0]          h,
    input logic [5:0]          m,
    input logic [5:0]          s
  );
    to_total = TOT_W'(d) * TOT_W'(SEC_PER_DAY) + TOT_W'(h) * TOT_W'(SEC_PER_HOUR)
             + TOT_W'(m) * TOT_W'(SEC_PER_MIN) + TOT_W'(s);
  endfunction

  logic [TOT_W-1:0] ta, tb;

  assign ta         = to_total(a_days_i, a_hours_i, a_minutes_i, a_seconds_i);
  assign tb         = to_total(b_days_i, b_hours_i, b_minutes_i, b_seconds_i);
  assign q_valid_o  = in_valid_i;
  assign in_ready_o = q_ready_i;

  // inc/dec fold into add/sub of one second
  always_comb begin
    item_o.ta     = ta;
    item_o.tb     = tb;
    item_o.factor = factor_i;
    unique case (operation_i)
      OP_ADD:   item_o.kind = K_ADD;
      OP_SUB:   item_o.kind = K_SUB;
      OP_SCALE: item_o.kind = K_MUL;
      OP_CMP:   item_o.kind = K_CMP;
      OP_INC: begin
        item_o.kind = K_ADD;
        item_o.tb   = TOT_W'(1);
      end
      OP_DEC: begin
        item_o.kind = K_SUB;
        item_o.tb   = TOT_W'(1);
      end
      default:  item_o.kind = K_NOP;
    endcase
  end

endmodule

// ----- rtl/dau_queue.sv -----
module dau_queue import dau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t item_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              push, pop;

  assign in_ready_o  = cnt_q != (QPTR_W+1)'(QDEPTH);
  assign out_valid_o = cnt_q != '0;
  assign item_o      = mem_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

// ----- rtl/dau_back.sv -----
module dau_back import dau_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  item_t               item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DAY_BITS-1:0] res_days_o,
  output logic [4:0]          res_hours_o,
  output logic [5:0]          res_minutes_o,
  output logic [5:0]          res_seconds_o,
  output flags_t              flags_o
);

  localparam int REM_W      = 17;
  localparam int MT_W       = 11;
  localparam int X_W        = TOT_W - 7;
  localparam int DAY_SH     = 34;
  localparam int DAY_RCP_W  = 25;
  localparam longint DAY_RCP = (64'd1 << DAY_SH) / 675;
  localparam int MIN_SH     = 24;
  localparam int MIN_RCP_W  = 19;
  localparam longint MIN_RCP = (64'd1 << MIN_SH) / 60 + 1;
  localparam int P3_W       = X_W + DAY_RCP_W;
  localparam int P6_W       = REM_W + MIN_RCP_W;
  localparam int P7_W       = MT_W + MIN_RCP_W;
  localparam logic [TOT_W-1:0] MAX_TOT =
    TOT_W'((64'd1 << DAY_BITS) * 64'd86400 - 64'd1);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, vo_q;

  logic signed [RES_W-1:0] r1_q;
  logic                    arith1_q;
  flags_t                  fl1_q, fl2_q, fl3_q, fl4_q, fl5_q, fl6_q, fl7_q, flo_q;
  logic [TOT_W-1:0]        t2_q, t3_q, t4_q, p4_q;
  logic [DAY_BITS-1:0]     q3_q, q4_q, days5_q, days6_q, days7_q, dayso_q;
  logic [REM_W-1:0]        rem5_q, rem6_q;
  logic [MT_W-1:0]         mt6_q, mt7_q;
  logic [4:0]              hrs7_q, hrso_q;
  logic [5:0]              sec7_q, seco_q, mino_q;

  logic signed [RES_W-1:0] ta_x, tb_x, prod1, r1_d;
  logic                    arith1_d;
  flags_t                  fl1_d, fl2_d;
  logic [TOT_W-1:0]        t2_d, rem0;
  logic [X_W-1:0]          x3;
  logic [P3_W-1:0]         prod3;
  logic [DAY_BITS-1:0]     days5_d;
  logic [REM_W-1:0]        rem5_d, sec_full;
  logic [P6_W-1:0]         prod6;
  logic [P7_W-1:0]         prod7;
  logic [MT_W-1:0]         min_full;

  assign en        = !vo_q || out_ready_i;
  assign s_ready_o = en;

  // stage 1: operation on totals
  assign ta_x  = $signed({{(RES_W-TOT_W){1'b0}}, item_i.ta});
  assign tb_x  = $signed({{(RES_W-TOT_W){1'b0}}, item_i.tb});
  assign prod1 = $signed({1'b0, item_i.ta}) * item_i.factor;

  always_comb begin
    r1_d     = '0;
    arith1_d = 1'b1;
    fl1_d    = '0;
    case (item_i.kind)
      K_ADD: r1_d = ta_x + tb_x;
      K_SUB: r1_d = ta_x - tb_x;
      K_MUL: r1_d = prod1;
      K_CMP: begin
        arith1_d = 1'b0;
        fl1_d.lt = item_i.ta < item_i.tb;
        fl1_d.eq = item_i.ta == item_i.tb;
        fl1_d.gt = item_i.ta > item_i.tb;
      end
      default: arith1_d = 1'b0;
    endcase
  end

  // stage 2: clamp / saturate
  always_comb begin
    fl2_d = fl1_q;
    t2_d  = r1_q[TOT_W-1:0];
    if (!arith1_q) begin
      t2_d = '0;
    end else if (r1_q <= 0) begin
      t2_d       = '0;
      fl2_d.zero = 1'b1;
    end else if (r1_q > $signed({{(RES_W-TOT_W){1'b0}}, MAX_TOT})) begin
      t2_d      = MAX_TOT;
      fl2_d.sat = 1'b1;
    end
  end

  // stage 3: day estimate, 86400 = 128 * 675
  assign x3    = t2_q[TOT_W-1:7];
  assign prod3 = P3_W'(x3) * P3_W'(DAY_RCP);

  // stage 5: one-step correction of the day estimate
  always_comb begin
    rem0    = t4_q - p4_q;
    days5_d = q4_q;
    rem5_d  = rem0[REM_W-1:0];
    if (rem0 >= TOT_W'(SEC_PER_DAY)) begin
      days5_d = q4_q + 1'b1;
      rem5_d  = REM_W'(rem0 - TOT_W'(SEC_PER_DAY));
    end
  end

  assign prod6    = P6_W'(rem5_q) * P6_W'(MIN_RCP);
  assign sec_full = rem6_q - REM_W'(mt6_q) * REM_W'(SEC_PER_MIN);
  assign prod7    = P7_W'(mt6_q) * P7_W'(MIN_RCP);
  assign min_full = mt7_q - MT_W'(hrs7_q) * MT_W'(SEC_PER_MIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      vo_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q     <= r1_d;
      arith1_q <= arith1_d;
      fl1_q    <= fl1_d;

      t2_q     <= t2_d;
      fl2_q    <= fl2_d;

      t3_q     <= t2_q;
      q3_q     <= prod3[DAY_SH +: DAY_BITS];
      fl3_q    <= fl2_q;

      t4_q     <= t3_q;
      q4_q     <= q3_q;
      p4_q     <= TOT_W'(q3_q) * TOT_W'(SEC_PER_DAY);
      fl4_q    <= fl3_q;

      days5_q  <= days5_d;
      rem5_q   <= rem5_d;
      fl5_q    <= fl4_q;

      days6_q  <= days5_q;
      rem6_q   <= rem5_q;
      mt6_q    <= prod6[MIN_SH +: MT_W];
      fl6_q    <= fl5_q;

      days7_q  <= days6_q;
      mt7_q    <= mt6_q;
      hrs7_q   <= prod7[MIN_SH +: 5];
      sec7_q   <= sec_full[5:0];
      fl7_q    <= fl6_q;

      dayso_q  <= days7_q;
      hrso_q   <= hrs7_q;
      mino_q   <= min_full[5:0];
      seco_q   <= sec7_q;
      flo_q    <= fl7_q;
    end
  end

  assign out_valid_o   = vo_q;
  assign res_days_o    = dayso_q;
  assign res_hours_o   = hrso_q;
  assign res_minutes_o = mino_q;
  assign res_seconds_o = seco_q;
  assign flags_o       = flo_q;

endmodule

// ----- rtl/duration_arithmetic_unit_core.sv -----
// Duration arithmetic on day/hour/minute/second values: add, subtract, scale by
// a signed factor, increment, decrement and compare, with results clamped to
// zero or saturated at the largest day count and flagged. One beat is accepted
// per cycle while the queue has room, and results leave in order through the
// eight-stage back pipeline (product, clamp, reciprocal multiplies for days,
// minutes and hours, and their corrections). A four-entry queue between the
// operand front end and the back pipeline keeps input acceptance going while a
// finished result waits.
module duration_arithmetic_unit_core import dau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               operation_i,
  input  logic [DAY_BITS-1:0]      a_days_i,
  input  logic [4:0]               a_hours_i,
  input  logic [5:0]               a_minutes_i,
  input  logic [5:0]               a_seconds_i,
  input  logic [DAY_BITS-1:0]      b_days_i,
  input  logic [4:0]               b_hours_i,
  input  logic [5:0]               b_minutes_i,
  input  logic [5:0]               b_seconds_i,
  input  logic signed [FACT_W-1:0] factor_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [DAY_BITS-1:0]      res_days_o,
  output logic [4:0]               res_hours_o,
  output logic [5:0]               res_minutes_o,
  output logic [5:0]               res_seconds_o,
  output logic                     clamped_zero_o,
  output logic                     saturated_o,
  output logic                     is_less_o,
  output logic                     is_equal_o,
  output logic                     is_greater_o
);

  item_t  front_item, q_item;
  logic   front_valid, front_ready, q_valid, q_ready;
  flags_t flags;

  dau_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .a_days_i    (a_days_i),
    .a_hours_i   (a_hours_i),
    .a_minutes_i (a_minutes_i),
    .a_seconds_i (a_seconds_i),
    .b_days_i    (b_days_i),
    .b_hours_i   (b_hours_i),
    .b_minutes_i (b_minutes_i),
    .b_seconds_i (b_seconds_i),
    .factor_i    (factor_i),
    .q_valid_o   (front_valid),
    .q_ready_i   (front_ready),
    .item_o      (front_item)
  );

  dau_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .item_i      (front_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .item_o      (q_item)
  );

  dau_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (q_valid),
    .s_ready_o     (q_ready),
    .item_i        (q_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .res_days_o    (res_days_o),
    .res_hours_o   (res_hours_o),
    .res_minutes_o (res_minutes_o),
    .res_seconds_o (res_seconds_o),
    .flags_o       (flags)
  );

  assign clamped_zero_o = flags.zero;
  assign saturated_o    = flags.sat;
  assign is_less_o      = flags.lt;
  assign is_equal_o     = flags.eq;
  assign is_greater_o   = flags.gt;

endmodule
